FILE: hdl/crmsmu_pkg.sv
// Shared types and constants for the centered RMSProp momentum update block.
// Depends on nothing; used by hdl/centered_rmsprop_momentum_update.sv.
package crmsmu_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 24;
    localparam int CFG_WIDTH  = 25;
    localparam int CFG_IDX_W  = 4;

    localparam logic [CFG_WIDTH-1:0] ONE_Q24 = CFG_WIDTH'(1) << FRAC_BITS;
    localparam logic [31:0]          EPS_Q24 = 32'd1678;

    // Register reset values
    localparam logic [CFG_WIDTH-1:0] LR_RESET = 25'd1678;
    localparam logic [CFG_WIDTH-1:0] DR_RESET = 25'd15938355;
    localparam logic [CFG_WIDTH-1:0] MG_RESET = 25'd15099494;
    localparam logic [CFG_WIDTH-1:0] WD_RESET = 25'd0;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_RATE    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MOMENTUM_GAIN = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_DECAY  = 4'd3;

    // Iteration counts: root of a 56-bit radicand, 38 quotient bits
    localparam int SQRT_STEPS = 28;
    localparam int DIV_STEPS  = 38;
    localparam int SQ_W       = 57;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] weight;
        logic signed [DATA_WIDTH-1:0] gradient;
        logic signed [DATA_WIDTH-1:0] running_mean;
        logic        [DATA_WIDTH-2:0] running_mean_square;
        logic signed [DATA_WIDTH-1:0] velocity;
        logic                         last_in;
    } in_word_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] new_weight;
        logic signed [DATA_WIDTH-1:0] new_mean;
        logic        [DATA_WIDTH-2:0] new_mean_square;
        logic signed [DATA_WIDTH-1:0] new_velocity;
        logic                         last_out;
    } out_word_t;

    // Fields that ride along the root and quotient sections
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] weight;
        logic signed [DATA_WIDTH-1:0] new_mean;
        logic        [DATA_WIDTH-2:0] new_ms;
        logic signed [DATA_WIDTH:0]   mv;
        logic signed [DATA_WIDTH:0]   lwr;
        logic                         neg;
        logic                         last;
    } carry_t;

endpackage

FILE: hdl/centered_rmsprop_momentum_update.sv
// Centered RMSProp step with momentum and weight decay, fully pipelined.
// Depends on crmsmu_pkg (hdl/crmsmu_pkg.sv).
//
// One word enters per cycle and one result word leaves per cycle, unless the
// output stalls. The pipeline has four multiply/round stages in front, the 28-stage
// square-root pipeline, one divider load stage, the 38-stage restoring divider
// (one bit per stage) and two saturation stages at the back. The whole pipeline
// advances together: it stalls only while the output register holds a word
// that the sink has not taken. Registers are written over the cfg channel,
// which is always ready; write them only while no word is in flight.
module centered_rmsprop_momentum_update (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  crmsmu_pkg::in_word_t                 s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output crmsmu_pkg::out_word_t                m_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [crmsmu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [crmsmu_pkg::CFG_WIDTH-1:0]     cfg_data
);

    localparam int NS = crmsmu_pkg::SQRT_STEPS;
    localparam int ND = crmsmu_pkg::DIV_STEPS;

    function automatic logic [crmsmu_pkg::CFG_WIDTH-1:0] sat_one(
        input logic [crmsmu_pkg::CFG_WIDTH-1:0] r);
        return (r > crmsmu_pkg::ONE_Q24) ? crmsmu_pkg::ONE_Q24 : r;
    endfunction

    function automatic logic signed [31:0] sat_s32(input logic signed [40:0] x);
        if (x > 41'sd2147483647)
            return 32'sh7fffffff;
        else if (x < -41'sd2147483648)
            return 32'sh80000000;
        else
            return x[31:0];
    endfunction

    // ---------------- configuration registers ----------------
    logic [24:0] lr_reg, dr_reg, mg_reg, wd_reg;
    logic [24:0] lr_eff, dr_eff, mg_eff, wd_eff, dc_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lr_reg <= crmsmu_pkg::LR_RESET;
            dr_reg <= crmsmu_pkg::DR_RESET;
            mg_reg <= crmsmu_pkg::MG_RESET;
            wd_reg <= crmsmu_pkg::WD_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                crmsmu_pkg::REG_LEARNING_RATE: lr_reg <= cfg_data;
                crmsmu_pkg::REG_DECAY_RATE:    dr_reg <= cfg_data;
                crmsmu_pkg::REG_MOMENTUM_GAIN: mg_reg <= cfg_data;
                crmsmu_pkg::REG_WEIGHT_DECAY:  wd_reg <= cfg_data;
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    // Settings above 1.0 act as exactly 1.0
    assign lr_eff = sat_one(lr_reg);
    assign dr_eff = sat_one(dr_reg);
    assign mg_eff = sat_one(mg_reg);
    assign wd_eff = sat_one(wd_reg);
    assign dc_eff = crmsmu_pkg::ONE_Q24 - dr_eff;

    // ---------------- pipeline advance ----------------
    logic en;
    logic out_vld_reg;

    // Advance everything unless the output word is held
    assign en      = !out_vld_reg || m_ready;
    assign s_ready = en;

    // ---------------- stage A: raw products ----------------
    logic                a_vld_reg;
    logic signed [63:0]  a_gg_reg, a_gg_next;
    logic signed [56:0]  a_dm_reg, a_dm_next, a_dg_reg, a_dg_next;
    logic signed [56:0]  a_lrg_reg, a_lrg_next, a_mv_reg, a_mv_next;
    logic        [49:0]  a_lw_reg, a_lw_next;
    logic signed [31:0]  a_w_reg;
    logic        [30:0]  a_s_reg;
    logic                a_last_reg;

    always_comb begin
        a_gg_next  = s_data.gradient * s_data.gradient;
        a_dm_next  = $signed({1'b0, dr_eff}) * s_data.running_mean;
        a_dg_next  = $signed({1'b0, dc_eff}) * s_data.gradient;
        a_lrg_next = $signed({1'b0, lr_eff}) * s_data.gradient;
        a_mv_next  = $signed({1'b0, mg_eff}) * s_data.velocity;
        a_lw_next  = lr_eff * wd_eff;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_gg_reg   <= a_gg_next;
            a_dm_reg   <= a_dm_next;
            a_dg_reg   <= a_dg_next;
            a_lrg_reg  <= a_lrg_next;
            a_mv_reg   <= a_mv_next;
            a_lw_reg   <= a_lw_next;
            a_w_reg    <= s_data.weight;
            a_s_reg    <= s_data.running_mean_square;
            a_last_reg <= s_data.last_in;
        end
    end

    // ---------------- stage B: round, blend mean, second products ----------------
    logic                b_vld_reg;
    logic        [62:0]  g2_rnd;
    logic        [38:0]  g2;
    logic signed [57:0]  msum;
    logic signed [56:0]  mv_rnd;
    logic        [49:0]  lw_rnd;
    logic signed [56:0]  lrg_abs;
    logic        [55:0]  b_ds_reg, b_ds_next;
    logic        [63:0]  b_dg2_reg, b_dg2_next;
    logic signed [31:0]  b_mnew_reg, b_mnew_next;
    logic signed [32:0]  b_mv_reg, b_mv_next;
    logic        [24:0]  b_lw_reg, b_lw_next;
    logic                b_neg_reg, b_neg_next;
    logic        [55:0]  b_mag_reg, b_mag_next;
    logic signed [31:0]  b_w_reg;
    logic                b_last_reg;

    always_comb begin
        g2_rnd      = a_gg_reg[62:0] + 63'(1 << 23);
        g2          = g2_rnd[62:24];
        b_ds_next   = dr_eff * a_s_reg;
        b_dg2_next  = dc_eff * g2;
        msum        = 58'(a_dm_reg) + 58'(a_dg_reg) + 58'sd8388608;
        b_mnew_next = sat_s32(41'($signed(msum[57:24])));
        mv_rnd      = a_mv_reg + 57'sd8388608;
        b_mv_next   = mv_rnd[56:24];
        lw_rnd      = a_lw_reg + 50'd8388608;
        b_lw_next   = lw_rnd[48:24];
        b_neg_next  = a_lrg_reg[56];
        lrg_abs     = a_lrg_reg[56] ? -a_lrg_reg : a_lrg_reg;
        b_mag_next  = lrg_abs[55:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_ds_reg   <= b_ds_next;
            b_dg2_reg  <= b_dg2_next;
            b_mnew_reg <= b_mnew_next;
            b_mv_reg   <= b_mv_next;
            b_lw_reg   <= b_lw_next;
            b_neg_reg  <= b_neg_next;
            b_mag_reg  <= b_mag_next;
            b_w_reg    <= a_w_reg;
            b_last_reg <= a_last_reg;
        end
    end

    // ---------------- stage C: blend mean square, m'^2, decay product ----------------
    logic                c_vld_reg;
    logic        [63:0]  ssum;
    logic        [39:0]  s_rnd;
    logic        [30:0]  c_snew_reg, c_snew_next;
    logic signed [63:0]  c_mm_reg, c_mm_next;
    logic signed [57:0]  c_lww_reg, c_lww_next;
    logic signed [31:0]  c_mnew_reg;
    logic signed [32:0]  c_mv_reg;
    logic                c_neg_reg;
    logic        [55:0]  c_mag_reg;
    logic signed [31:0]  c_w_reg;
    logic                c_last_reg;

    always_comb begin
        ssum        = 64'(b_ds_reg) + b_dg2_reg + 64'd8388608;
        s_rnd       = ssum[63:24];
        c_snew_next = (s_rnd > 40'h007fffffff) ? 31'h7fffffff : s_rnd[30:0];
        c_mm_next   = b_mnew_reg * b_mnew_reg;
        c_lww_next  = $signed({1'b0, b_lw_reg}) * b_w_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_snew_reg <= c_snew_next;
            c_mm_reg   <= c_mm_next;
            c_lww_reg  <= c_lww_next;
            c_mnew_reg <= b_mnew_reg;
            c_mv_reg   <= b_mv_reg;
            c_neg_reg  <= b_neg_reg;
            c_mag_reg  <= b_mag_reg;
            c_w_reg    <= b_w_reg;
            c_last_reg <= b_last_reg;
        end
    end

    // ---------------- stage D: variance, radicand (square-root stage 0) ----------------
    logic        [62:0]  mm_rnd;
    logic signed [40:0]  var_raw;
    logic        [30:0]  var_cl;
    logic        [31:0]  var_eps;
    logic signed [57:0]  lww_rnd;

    logic                   sq_vld_reg [0:NS];
    logic [crmsmu_pkg::SQ_W-1:0] sq_x_reg   [0:NS];
    logic [crmsmu_pkg::SQ_W-1:0] sq_r_reg   [0:NS];
    logic [55:0]            sq_mag_reg [0:NS];
    crmsmu_pkg::carry_t     sq_c_reg   [0:NS];
    logic [crmsmu_pkg::SQ_W-1:0] sq_x_next  [0:NS];
    logic [crmsmu_pkg::SQ_W-1:0] sq_r_next  [0:NS];
    crmsmu_pkg::carry_t     sq_c0_next;

    always_comb begin
        mm_rnd   = c_mm_reg[62:0] + 63'd8388608;
        var_raw  = $signed({10'b0, c_snew_reg}) - $signed({2'b0, mm_rnd[62:24]});
        // Clamp a negative variance to zero before adding epsilon
        var_cl   = var_raw[40] ? 31'd0 : var_raw[30:0];
        var_eps  = {1'b0, var_cl} + crmsmu_pkg::EPS_Q24;
        sq_x_next[0] = 57'({var_eps, 24'd0});
        sq_r_next[0] = '0;
        lww_rnd  = c_lww_reg + 58'sd8388608;
        sq_c0_next.weight   = c_w_reg;
        sq_c0_next.new_mean = c_mnew_reg;
        sq_c0_next.new_ms   = c_snew_reg;
        sq_c0_next.mv       = c_mv_reg;
        sq_c0_next.lwr      = lww_rnd[56:24];
        sq_c0_next.neg      = c_neg_reg;
        sq_c0_next.last     = c_last_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_x_reg[0]   <= sq_x_next[0];
            sq_r_reg[0]   <= sq_r_next[0];
            sq_mag_reg[0] <= c_mag_reg;
            sq_c_reg[0]   <= sq_c0_next;
        end
    end

    // ---------------- square-root pipeline: one result bit per stage ----------------
    for (genvar i = 1; i <= NS; i++) begin : g_sqrt
        localparam logic [crmsmu_pkg::SQ_W-1:0] ONE_BIT = 57'(1) << (54 - 2 * (i - 1));
        logic [crmsmu_pkg::SQ_W-1:0] trial;

        always_comb begin
            trial = sq_r_reg[i-1] + ONE_BIT;
            if (sq_x_reg[i-1] >= trial) begin
                sq_x_next[i] = sq_x_reg[i-1] - trial;
                sq_r_next[i] = (sq_r_reg[i-1] >> 1) + ONE_BIT;
            end else begin
                sq_x_next[i] = sq_x_reg[i-1];
                sq_r_next[i] = sq_r_reg[i-1] >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sq_x_reg[i]   <= sq_x_next[i];
                sq_r_reg[i]   <= sq_r_next[i];
                sq_mag_reg[i] <= sq_mag_reg[i-1];
                sq_c_reg[i]   <= sq_c_reg[i-1];
            end
        end
    end

    // ---------------- divider: |lr*g| / k, one quotient bit per stage ----------------
    logic                  dv_vld_reg [0:ND];
    logic [27:0]           dv_k_reg   [0:ND];
    logic [27:0]           dv_rem_reg [0:ND];
    logic [37:0]           dv_dd_reg  [0:ND];
    logic [37:0]           dv_q_reg   [0:ND];
    crmsmu_pkg::carry_t    dv_c_reg   [0:ND];
    logic [27:0]           dv_rem_next [1:ND];
    logic [37:0]           dv_q_next   [1:ND];

    // The top 18 dividend bits are always below k, so start with them as remainder
    always_ff @(posedge aclk) begin
        if (en) begin
            dv_k_reg[0]   <= sq_r_reg[NS][27:0];
            dv_rem_reg[0] <= {10'd0, sq_mag_reg[NS][55:38]};
            dv_dd_reg[0]  <= sq_mag_reg[NS][37:0];
            dv_q_reg[0]   <= '0;
            dv_c_reg[0]   <= sq_c_reg[NS];
        end
    end

    for (genvar j = 1; j <= ND; j++) begin : g_div
        logic [28:0] tr;
        logic [28:0] diff;

        always_comb begin
            tr   = {dv_rem_reg[j-1], dv_dd_reg[j-1][37]};
            diff = tr - {1'b0, dv_k_reg[j-1]};
            if (tr >= {1'b0, dv_k_reg[j-1]}) begin
                dv_rem_next[j] = diff[27:0];
                dv_q_next[j]   = {dv_q_reg[j-1][36:0], 1'b1};
            end else begin
                dv_rem_next[j] = tr[27:0];
                dv_q_next[j]   = {dv_q_reg[j-1][36:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_k_reg[j]   <= dv_k_reg[j-1];
                dv_rem_reg[j] <= dv_rem_next[j];
                dv_dd_reg[j]  <= {dv_dd_reg[j-1][36:0], 1'b0};
                dv_q_reg[j]   <= dv_q_next[j];
                dv_c_reg[j]   <= dv_c_reg[j-1];
            end
        end
    end

    // ---------------- stage V: signed step, new velocity ----------------
    logic                 v_vld_reg;
    logic signed [38:0]   step_val;
    logic signed [40:0]   v_wide;
    logic signed [31:0]   v_vnew_reg, v_vnew_next;
    crmsmu_pkg::carry_t   v_c_reg;

    always_comb begin
        // Quotient truncates toward zero: apply the sign to the magnitude
        step_val    = dv_c_reg[ND].neg ? -$signed({1'b0, dv_q_reg[ND]})
                                       : $signed({1'b0, dv_q_reg[ND]});
        v_wide      = 41'(dv_c_reg[ND].mv) - 41'(step_val);
        v_vnew_next = sat_s32(v_wide);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v_vnew_reg <= v_vnew_next;
            v_c_reg    <= dv_c_reg[ND];
        end
    end

    // ---------------- output register: new weight ----------------
    crmsmu_pkg::out_word_t out_reg, out_next;
    logic signed [40:0]    w_wide;

    always_comb begin
        w_wide   = 41'(v_c_reg.weight) + 41'(v_vnew_reg) - 41'(v_c_reg.lwr);
        out_next.new_weight      = sat_s32(w_wide);
        out_next.new_mean        = v_c_reg.new_mean;
        out_next.new_mean_square = v_c_reg.new_ms;
        out_next.new_velocity    = v_vnew_reg;
        out_next.last_out        = v_c_reg.last;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

    // ---------------- valid bits, moving with the data ----------------
    logic c_vld_d;
    assign c_vld_d = c_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg   <= 1'b0;
            b_vld_reg   <= 1'b0;
            c_vld_reg   <= 1'b0;
            for (int i = 0; i <= NS; i++) sq_vld_reg[i] <= 1'b0;
            for (int j = 0; j <= ND; j++) dv_vld_reg[j] <= 1'b0;
            v_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg     <= s_valid;
            b_vld_reg     <= a_vld_reg;
            c_vld_reg     <= b_vld_reg;
            sq_vld_reg[0] <= c_vld_d;
            for (int i = 1; i <= NS; i++) sq_vld_reg[i] <= sq_vld_reg[i-1];
            dv_vld_reg[0] <= sq_vld_reg[NS];
            for (int j = 1; j <= ND; j++) dv_vld_reg[j] <= dv_vld_reg[j-1];
            v_vld_reg     <= dv_vld_reg[ND];
            out_vld_reg   <= v_vld_reg;
        end
    end

    // ---------------- assertions ----------------
    // The root feeding the divider is never zero (epsilon keeps it above 2^17)
    a_root_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        dv_vld_reg[0] |-> dv_k_reg[0] != 28'd0)
        else $error("divider entered with zero divisor");

    // The remainder stays below the divisor through the whole divider
    a_rem_below_k: assert property (@(posedge aclk) disable iff (!aresetn)
        dv_vld_reg[ND] |-> dv_rem_reg[ND] < dv_k_reg[ND])
        else $error("divider remainder not below divisor");

    // A stall freezes the word waiting behind the output register
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(v_vld_reg) && $stable(v_vnew_reg))
        else $error("pipeline moved during a stall");

endmodule

FILE: tb/tb.sv
// Self-checking testbench for centered_rmsprop_momentum_update.
// Depends on crmsmu_pkg and the block in hdl/; it predicts each result word and compares.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // A long hold-off plus a full pipeline is the slowest quiet stretch.
    localparam int QUIET_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 100;
    localparam longint ONE = 64'sd16777216;
    localparam longint SMAX = 64'sd2147483647;
    localparam longint SMIN = -64'sd2147483648;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    crmsmu_pkg::in_word_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    crmsmu_pkg::out_word_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [crmsmu_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [crmsmu_pkg::CFG_WIDTH-1:0] cfg_data = '0;

    // Shadow copy of the block's registers
    logic [crmsmu_pkg::CFG_WIDTH-1:0] lr_reg = crmsmu_pkg::LR_RESET;
    logic [crmsmu_pkg::CFG_WIDTH-1:0] dr_reg = crmsmu_pkg::DR_RESET;
    logic [crmsmu_pkg::CFG_WIDTH-1:0] mg_reg = crmsmu_pkg::MG_RESET;
    logic [crmsmu_pkg::CFG_WIDTH-1:0] wd_reg = crmsmu_pkg::WD_RESET;

    crmsmu_pkg::out_word_t pending_updates[$];
    int mismatches = 0;
    int quiet_cycles = 0;
    int hold_off_left = 0;
    int sink_stall_left = 0;
    bit steady_flow = 0;

    always #1 aclk = ~aclk;

    centered_rmsprop_momentum_update u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Registers above 1.0 act as exactly 1.0.
    function automatic longint gain(logic [crmsmu_pkg::CFG_WIDTH-1:0] r);
        return (longint'(r) > ONE) ? ONE : longint'(r);
    endfunction

    // Rescale by 2^-24, round to nearest with ties toward +inf.
    function automatic longint round24(longint x);
        return (x + 64'sd8388608) >>> 24;
    endfunction

    function automatic longint clip(longint x, longint lo, longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    function automatic longint unsigned floor_root(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic crmsmu_pkg::out_word_t rmsprop_update(crmsmu_pkg::in_word_t x);
        longint lr, d, mg, wd, w, g, m, s, v;
        longint ms_new, mean_new, spread, vel_new, lw, w_new;
        longint unsigned root;
        crmsmu_pkg::out_word_t y;
        lr = gain(lr_reg);
        d = gain(dr_reg);
        mg = gain(mg_reg);
        wd = gain(wd_reg);
        w = longint'(x.weight);
        g = longint'(x.gradient);
        m = longint'(x.running_mean);
        s = longint'({1'b0, x.running_mean_square});
        v = longint'(x.velocity);
        ms_new = clip(round24(d * s + (ONE - d) * round24(g * g)), 0, SMAX);
        mean_new = clip(round24(d * m + (ONE - d) * g), SMIN, SMAX);
        spread = ms_new - round24(mean_new * mean_new);
        if (spread < 0) spread = 0;
        root = floor_root(longint'(unsigned'(spread + 1678)) << 24);
        vel_new = clip(round24(mg * v) - (lr * g) / longint'(root), SMIN, SMAX);
        lw = round24(lr * wd);
        w_new = clip(w + vel_new - round24(lw * w), SMIN, SMAX);
        y.new_weight = w_new[31:0];
        y.new_mean = mean_new[31:0];
        y.new_mean_square = ms_new[30:0];
        y.new_velocity = vel_new[31:0];
        y.last_out = x.last_in;
        return y;
    endfunction

    task automatic report(string field, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
        mismatches++;
    endtask

    // Check each result word against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_updates.size() == 0) begin
                report("unexpected word", 0, 0);
            end else begin
                crmsmu_pkg::out_word_t want;
                want = pending_updates.pop_front();
                if (m_data.new_weight !== want.new_weight)
                    report("new_weight", m_data.new_weight, want.new_weight);
                if (m_data.new_mean !== want.new_mean)
                    report("new_mean", m_data.new_mean, want.new_mean);
                if (m_data.new_mean_square !== want.new_mean_square)
                    report("new_mean_square", m_data.new_mean_square,
                           want.new_mean_square);
                if (m_data.new_velocity !== want.new_velocity)
                    report("new_velocity", m_data.new_velocity, want.new_velocity);
                if (m_data.last_out !== want.last_out)
                    report("last_out", m_data.last_out, want.last_out);
            end
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow || r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sink side: random stalls, plus a long hold-off when a test asks for it.
    always @(posedge aclk) begin
        if (hold_off_left > 0) begin
            m_ready <= 1'b0;
            hold_off_left <= hold_off_left - 1;
        end else if (sink_stall_left > 0) begin
            m_ready <= 1'b0;
            sink_stall_left <= sink_stall_left - 1;
        end else if (!steady_flow && $urandom_range(0, 99) < 20) begin
            m_ready <= 1'b0;
            sink_stall_left <= pick_gap();
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Send one word; hold valid and payload until accepted, then log the prediction.
    task automatic send_word(crmsmu_pkg::in_word_t x);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= x;
        do @(posedge aclk); while (!s_ready);
        pending_updates.push_back(rmsprop_update(x));
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_updates.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Offer one register write and hold it until accepted; the caller drops valid.
    task automatic write_reg(logic [crmsmu_pkg::CFG_IDX_W-1:0] idx,
                             logic [crmsmu_pkg::CFG_WIDTH-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            crmsmu_pkg::REG_LEARNING_RATE: lr_reg = val;
            crmsmu_pkg::REG_DECAY_RATE: dr_reg = val;
            crmsmu_pkg::REG_MOMENTUM_GAIN: mg_reg = val;
            crmsmu_pkg::REG_WEIGHT_DECAY: wd_reg = val;
            default: ;
        endcase
    endtask

    task automatic set_all(logic [crmsmu_pkg::CFG_WIDTH-1:0] lr,
                           logic [crmsmu_pkg::CFG_WIDTH-1:0] dr,
                           logic [crmsmu_pkg::CFG_WIDTH-1:0] mg,
                           logic [crmsmu_pkg::CFG_WIDTH-1:0] wd);
        wait_idle();
        write_reg(crmsmu_pkg::REG_LEARNING_RATE, lr);
        write_reg(crmsmu_pkg::REG_DECAY_RATE, dr);
        write_reg(crmsmu_pkg::REG_MOMENTUM_GAIN, mg);
        write_reg(crmsmu_pkg::REG_WEIGHT_DECAY, wd);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [crmsmu_pkg::CFG_WIDTH-1:0] rand_gain();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return crmsmu_pkg::ONE_Q24;
        if (r == 2) return 25'($urandom_range(16777217, 33554431));
        return 25'($urandom_range(0, 16777216));
    endfunction

    // Half the words carry realistic small values, the rest any bit pattern.
    function automatic crmsmu_pkg::in_word_t rand_word();
        crmsmu_pkg::in_word_t x;
        x = {$urandom, $urandom, $urandom, $urandom, $urandom};
        if ($urandom_range(0, 1)) begin
            x.weight = $signed(32'($urandom_range(0, 67108863))) - 32'sd33554432;
            x.gradient = $signed(32'($urandom_range(0, 16777215))) - 32'sd8388608;
            x.running_mean = $signed(32'($urandom_range(0, 4194303))) - 32'sd2097152;
            x.running_mean_square = 31'($urandom_range(0, 8388607));
            x.velocity = $signed(32'($urandom_range(0, 2097151))) - 32'sd1048576;
        end
        x.last_in = ($urandom_range(0, 15) == 0);
        return x;
    endfunction

    function automatic crmsmu_pkg::in_word_t make_word(logic [31:0] w, logic [31:0] g,
                                                       logic [31:0] m, logic [30:0] s,
                                                       logic [31:0] v, logic last);
        crmsmu_pkg::in_word_t x;
        x.weight = w;
        x.gradient = g;
        x.running_mean = m;
        x.running_mean_square = s;
        x.velocity = v;
        x.last_in = last;
        return x;
    endfunction

    // Field extremes, clamped variance and saturation, at reset settings first.
    task automatic test_directed();
        send_word(make_word(0, 0, 0, '0, 0, 1'b0));
        send_word(make_word(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff,
                            32'h7fffffff, 1'b1));
        send_word(make_word(32'h80000000, 32'h80000000, 32'h80000000, '0,
                            32'h80000000, 1'b0));
        send_word(make_word(32'h01000000, 32'h00100000, 32'h04000000, 31'h10,
                            32'h00010000, 1'b0)); // mean squared exceeds mean square
        send_word(make_word(32'hff000000, 32'hfff00000, 32'h00000001, 31'h01000000,
                            32'hffff0000, 1'b1));
        // Full learning rate and momentum, registers above 1.0: drive saturation.
        set_all(25'h1ffffff, 25'd0, 25'h1ffffff, 25'h1ffffff);
        send_word(make_word(32'h7fffffff, 32'h80000000, 0, '0, 32'h7fffffff, 1'b0));
        send_word(make_word(32'h80000000, 32'h7fffffff, 0, '0, 32'h80000000, 1'b1));
        send_word(make_word(32'h00000001, 32'hffffffff, 32'h7fffffff, 31'h1,
                            32'h00000001, 1'b0));
        set_all(crmsmu_pkg::ONE_Q24, crmsmu_pkg::ONE_Q24, 25'd0, crmsmu_pkg::ONE_Q24);
        send_word(make_word(32'h7fffffff, 32'h7fffffff, 32'h80000000, 31'h7fffffff,
                            32'h7fffffff, 1'b1));
        send_word(make_word(32'h12345678, 32'hedcba987, 32'h00ffffff, 31'h00abcdef,
                            32'h80000001, 1'b0));
    endtask

    // Phases of random words under random settings, one phase with no idling.
    task automatic test_random(int phases, int per_phase);
        for (int p = 0; p < phases; p++) begin
            set_all(rand_gain(), rand_gain(), rand_gain(), rand_gain());
            steady_flow = (p == 1);
            for (int i = 0; i < per_phase; i++) send_word(rand_word());
            steady_flow = 0;
        end
    endtask

    // Hold off the sink while words keep coming so the input stalls.
    task automatic test_backpressure();
        wait_idle();
        hold_off_left = 400;
        for (int i = 0; i < 150; i++) send_word(rand_word());
    endtask

    // Pause the source until every result is back, then resume.
    task automatic test_drain_pause();
        for (int i = 0; i < 20; i++) send_word(rand_word());
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_updates.size() != 0) @(posedge aclk);
        for (int i = 0; i < 20; i++) send_word(rand_word());
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(5, 200);
        test_backpressure();
        test_drain_pause();
        set_all(crmsmu_pkg::LR_RESET, crmsmu_pkg::DR_RESET, crmsmu_pkg::MG_RESET,
                crmsmu_pkg::WD_RESET);
        for (int i = 0; i < 40; i++) send_word(rand_word());
        wait_idle();
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

FILE: filelist.f
hdl/crmsmu_pkg.sv
hdl/centered_rmsprop_momentum_update.sv
tb/tb.sv
